// File: rtl/pic_pkg.sv
package pic_pkg;

	localparam int MAX_LEN = 256;
	localparam int VAL_W   = 8;
	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int TOT_W   = 15;
	localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

	// token moving down the cell chain
	typedef struct packed {
		logic             vld;
		logic [VAL_W-1:0] value;
		logic             last;
		logic             stored;  // already parked in a cell
		logic [CNT_W-1:0] cnt;     // held values greater than this one
	} tok_t;

endpackage

// File: rtl/pic_cell.sv
module pic_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  pic_pkg::tok_t tok_in,
	output pic_pkg::tok_t tok_out
);
	import pic_pkg::*;

	logic             hv_q;
	logic [VAL_W-1:0] hval_q;
	tok_t             tok_q;
	tok_t             tok_d;
	logic             gt;
	logic             take;

	assign gt   = tok_in.vld && hv_q && (hval_q > tok_in.value);
	assign take = tok_in.vld && !tok_in.stored && !hv_q;

	always_comb begin
		tok_d        = tok_in;
		tok_d.cnt    = tok_in.cnt + CNT_W'(gt);
		tok_d.stored = tok_in.stored | take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q  <= 1'b0;
			tok_q <= '0;
		end else if (adv) begin
			tok_q <= tok_d;
			// last element empties the cell behind it for the next sequence
			if (tok_in.vld && tok_in.last) begin
				hv_q <= 1'b0;
			end else if (take) begin
				hv_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && take) begin
			hval_q <= tok_in.value;
		end
	end

	assign tok_out = tok_q;

endmodule

// File: rtl/pic_accum.sv
module pic_accum (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  pic_pkg::tok_t             tok_in,
	output logic                      result_valid,
	output logic [pic_pkg::TOT_W-1:0] inversions,
	output logic                      overflow
);
	import pic_pkg::*;

	logic [TOT_W-1:0] total_q;
	logic             ovf_q;
	logic             rvld_q;
	logic [TOT_W-1:0] inv_q;
	logic             rovf_q;
	logic [TOT_W:0]   sum;
	logic [TOT_W-1:0] total_d;
	logic             ovf_d;

	assign sum = {1'b0, total_q} + (TOT_W + 1)'(tok_in.cnt);

	always_comb begin
		total_d = total_q;
		ovf_d   = ovf_q;
		if (tok_in.vld) begin
			if (tok_in.stored) begin
				total_d = sum[TOT_W] ? TOT_MAX : sum[TOT_W-1:0];
			end else begin
				ovf_d = 1'b1;  // found no free cell
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			ovf_q   <= 1'b0;
			rvld_q  <= 1'b0;
		end else if (adv) begin
			if (tok_in.vld && tok_in.last) begin
				total_q <= '0;
				ovf_q   <= 1'b0;
				rvld_q  <= 1'b1;
			end else begin
				total_q <= total_d;
				ovf_q   <= ovf_d;
				rvld_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tok_in.vld && tok_in.last) begin
			inv_q  <= total_d;
			rovf_q <= ovf_d;
		end
	end

	assign result_valid = rvld_q;
	assign inversions   = inv_q;
	assign overflow     = rovf_q;

endmodule

// File: rtl/permutation_inversion_counter.sv
// A sample's token passes through the 256 cell registers and then one output register to reach the result.
// Throughput: one sample per cycle while the chain is not stalled; the cell chain is a systolic pipeline.
// A stalled, full output register freezes the whole chain and stalls the input.
// Reset (arst_n, async, active low) empties all cells and clears totals and valids.
module permutation_inversion_counter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      sample_valid,
	output logic                      sample_stall,
	input  logic [pic_pkg::VAL_W-1:0] value,
	input  logic                      last,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic [pic_pkg::TOT_W-1:0] inversions,
	output logic                      overflow
);
	import pic_pkg::*;

	// link[i] feeds cell i; link[MAX_LEN] leaves the chain
	tok_t link [0:MAX_LEN];
	logic adv;

	// The chain moves unless a finished result is waiting and stalled.
	assign adv          = !(result_valid && result_stall);
	assign sample_stall = !adv;

	// Incoming sample enters as a fresh token: nothing counted, not yet parked.
	always_comb begin
		link[0]        = '0;
		link[0].vld    = sample_valid;
		link[0].value  = value;
		link[0].last   = last;
		link[0].stored = 1'b0;
		link[0].cnt    = '0;
	end

	// Each token walks the cells in order, counting greater held values, and parks
	// in the first empty cell. Earlier tokens always run ahead, so every held value
	// a token meets belongs to an earlier element. A last token empties each cell
	// it passes, leaving a clean chain for the next sequence right behind it.
	for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
		pic_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.tok_in  (link[i]),
			.tok_out (link[i+1])
		);
	end

	// Tokens leave in order; sum per-sequence counts, flag unparked tokens,
	// and emit the result on the last one.
	pic_accum u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.tok_in       (link[MAX_LEN]),
		.result_valid (result_valid),
		.inversions   (inversions),
		.overflow     (overflow)
	);

endmodule
